// ----- src/calibration_table_interpolator_core_defines.svh -----
// Assertion macros for the calibration table interpolator core.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define CTI_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CTI_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cti_pkg.sv -----
`timescale 1ns / 1ps
package cti_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W  = 16;
    localparam int FREQ_W = 24;
    localparam int PROD_W = KEY_W + FREQ_W;
    localparam int DIV_STEPS = FREQ_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] CFG_BURST  = 2'd0;
    localparam logic [1:0] CFG_CENTER = 2'd1;
    localparam logic [1:0] CFG_SLOPE  = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage

// ----- src/cti_div.sv -----
`timescale 1ns / 1ps
module cti_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cti_pkg::PROD_W-1:0]   num,
    input  logic [cti_pkg::KEY_W-1:0]    den,
    output cti_pkg::div_stat_t           stat,
    output logic [cti_pkg::FREQ_W-1:0]   quo
);
    import cti_pkg::*;

    // Quotient is known to fit FREQ_W bits, so the top KEY_W numerator bits
    // are already below the divisor and seed the remainder directly.
    logic [KEY_W-1:0]  rem_reg;
    logic [FREQ_W-1:0] q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [KEY_W:0]    trial;
    logic [KEY_W:0]    diff;
    logic              take;

    always_comb begin
        trial = {rem_reg, q_reg[FREQ_W-1]};
        diff  = trial - {1'b0, den};
        take  = (trial >= {1'b0, den});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_STEPS);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[PROD_W-1:FREQ_W];
            q_reg   <= num[FREQ_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= take ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
            q_reg   <= {q_reg[FREQ_W-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo = q_reg;
endmodule

// ----- src/calibration_table_interpolator_core.sv -----
`timescale 1ns / 1ps
// Calibration table interpolator: a sorted table of up to TABLE_DEPTH
// (key, frequency) pairs with one result beat per command beat. Insert
// updates a matching key or places a new key in order (status 1 for a new
// key when the table is full), clear empties the table, lookup clamps
// outside the key span and interpolates linearly inside it, truncating
// toward zero; with an empty table a lookup uses burst_freq + empty_slope *
// (key - center_voltage) saturated to 24 bits. One command at a time:
// s_tready is high only while the sequencer is idle. Timing is set by the
// single-port table scan and by the shared multiplier and 24-step serial
// divider: clear and unused commands go straight to the result; an insert
// scans to its slot, moves each later entry up one place and writes; a
// lookup inside the table scans, then multiplies and divides; an
// empty-table lookup uses only the multiplier and clamped lookups use
// neither. No clearing pass follows reset; entries are only read once
// written. Configuration writes are always taken (cfg_ready is high).
`include "calibration_table_interpolator_core_defines.svh"
module calibration_table_interpolator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] key, [39:16] value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] status, [24:1] frequency,
                                   // [29:25] entries_held, [31:30] zero
);
    import cti_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN_RD  = 4'd1;
    localparam logic [3:0] ST_SCAN_CHK = 4'd2;
    localparam logic [3:0] ST_SHIFT_RD = 4'd3;
    localparam logic [3:0] ST_SHIFT_WR = 4'd4;
    localparam logic [3:0] ST_INS_WR   = 4'd5;
    localparam logic [3:0] ST_MUL      = 4'd6;
    localparam logic [3:0] ST_ROUGH    = 4'd7;
    localparam logic [3:0] ST_DIV_GO   = 4'd8;
    localparam logic [3:0] ST_DIV_WAIT = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    // configuration registers
    logic [FREQ_W-1:0] burst_reg;
    logic [KEY_W-1:0]  center_reg;
    logic [7:0]        slope_reg;

    // sequencer state
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [FREQ_W-1:0] val_reg;
    logic [KEY_W-1:0]  prev_key_reg;
    logic [FREQ_W-1:0] prev_val_reg;
    logic              neg_reg;
    logic [FREQ_W-1:0] mul_a_reg;
    logic [KEY_W-1:0]  mul_b_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KEY_W-1:0]  dv_reg;
    logic [FREQ_W-1:0] res_freq_reg;
    logic              res_status_reg;

    // output register
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;

    // table storage, single write port and one registered read port
    logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
    logic [FREQ_W-1:0] val_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  key_rd;
    logic [FREQ_W-1:0] val_rd;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;
    logic [KEY_W-1:0]  wr_key;
    logic [FREQ_W-1:0] wr_val;

    // divider
    div_stat_t         div_stat;
    logic [FREQ_W-1:0] div_quo;

    logic              s_beat;
    logic              last_idx;
    logic              full;
    logic [KEY_W:0]    rough_diff;
    logic [FREQ_W:0]   rough_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign last_idx   = ((idx_reg + CNT_W'(1)) == count_reg);
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign rough_diff = {1'b0, s_tdata[KEY_W-1:0]} - {1'b0, center_reg};
    assign rough_sum  = {1'b0, burst_reg} + {1'b0, prod_reg[FREQ_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg  <= 24'd4000000;
            center_reg <= 16'd16500;
            slope_reg  <= 8'd10;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BURST:  burst_reg  <= cfg_data;
                CFG_CENTER: center_reg <= cfg_data[KEY_W-1:0];
                CFG_SLOPE:  slope_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Address and write selection for the table port.
    always_comb begin
        rd_addr = idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_key  = key_reg;
        wr_val  = val_reg;
        case (state_reg)
            ST_SHIFT_RD: rd_addr = IDX_W'(idx_reg - CNT_W'(1));
            ST_SHIFT_WR: begin
                wr_en  = 1'b1;
                wr_key = key_rd;
                wr_val = val_rd;
            end
            ST_INS_WR: wr_en = 1'b1;
            ST_SCAN_CHK: wr_en = (cmd_reg == CMD_INSERT) && (key_rd == key_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        key_rd <= key_mem[rd_addr];
        val_rd <= val_mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    case (s_tuser)
                        CMD_INSERT: state_next = (count_reg == '0) ? ST_INS_WR : ST_SCAN_RD;
                        CMD_LOOKUP: state_next = (count_reg == '0) ? ST_MUL : ST_SCAN_RD;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (key_rd == key_reg) begin
                        state_next = ST_DONE;
                    end else if (key_rd > key_reg) begin
                        state_next = full ? ST_DONE : ST_SHIFT_RD;
                    end else if (last_idx) begin
                        state_next = full ? ST_DONE : ST_INS_WR;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    if (key_reg <= key_rd && idx_reg == '0) begin
                        state_next = ST_DONE;
                    end else if (key_reg < key_rd) begin
                        state_next = ST_MUL;
                    end else if (last_idx) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: begin
                state_next = ((idx_reg - CNT_W'(1)) == pos_reg) ? ST_INS_WR : ST_SHIFT_RD;
            end
            ST_INS_WR: state_next = ST_DONE;
            ST_MUL:    state_next = (count_reg == '0) ? ST_ROUGH : ST_DIV_GO;
            ST_ROUGH:  state_next = ST_DONE;
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_stat.done) state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Load the result register when it is free or draining, else drop valid on a beat.
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: if (s_beat && s_tuser == CMD_CLEAR) count_reg <= '0;
                ST_INS_WR: count_reg <= count_reg + CNT_W'(1);
                default: ;
            endcase
        end
    end

    // Datapath registers, steered by the sequencer state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg        <= s_tuser;
                key_reg        <= s_tdata[KEY_W-1:0];
                val_reg        <= s_tdata[KEY_W+FREQ_W-1:KEY_W];
                idx_reg        <= '0;
                res_freq_reg   <= '0;
                res_status_reg <= 1'b0;
                // rough model: magnitude of key minus center, sign kept apart
                neg_reg   <= rough_diff[KEY_W];
                mul_a_reg <= FREQ_W'(slope_reg);
                mul_b_reg <= rough_diff[KEY_W] ? KEY_W'(-rough_diff) : rough_diff[KEY_W-1:0];
            end
            ST_SCAN_CHK: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (key_rd > key_reg) begin
                        pos_reg        <= idx_reg;
                        idx_reg        <= count_reg;
                        res_status_reg <= full;
                    end else if (key_rd != key_reg) begin
                        idx_reg        <= idx_reg + CNT_W'(1);
                        res_status_reg <= last_idx && full;
                    end
                end else begin
                    if (key_reg <= key_rd && idx_reg == '0) begin
                        res_freq_reg <= val_rd;
                    end else if (key_reg < key_rd) begin
                        neg_reg      <= (val_rd < prev_val_reg);
                        mul_a_reg    <= (val_rd < prev_val_reg) ? prev_val_reg - val_rd
                                                                : val_rd - prev_val_reg;
                        mul_b_reg    <= key_reg - prev_key_reg;
                        dv_reg       <= key_rd - prev_key_reg;
                    end else if (last_idx) begin
                        res_freq_reg <= val_rd;
                    end else begin
                        prev_key_reg <= key_rd;
                        prev_val_reg <= val_rd;
                        idx_reg      <= idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_SHIFT_WR: idx_reg <= idx_reg - CNT_W'(1);
            // widen both operands so the full product is kept
            ST_MUL: prod_reg <= {{KEY_W{1'b0}}, mul_a_reg} * {{FREQ_W{1'b0}}, mul_b_reg};
            ST_ROUGH: begin
                if (neg_reg) begin
                    res_freq_reg <= (prod_reg[FREQ_W-1:0] > burst_reg) ? '0
                                    : burst_reg - prod_reg[FREQ_W-1:0];
                end else begin
                    res_freq_reg <= rough_sum[FREQ_W] ? FREQ_MAX : rough_sum[FREQ_W-1:0];
                end
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    res_freq_reg <= neg_reg ? prev_val_reg - div_quo : prev_val_reg + div_quo;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {2'b00, 5'(count_reg), res_freq_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    cti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIV_GO),
        .num     (prod_reg),
        .den     (dv_reg),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    `CTI_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
    `CTI_ASSERT_IMP(a_full_status, aclk, aresetn, m_valid_reg && m_data_reg[0],
        m_data_reg[29:25] == 5'(TABLE_DEPTH), "full status with table not full")
    `CTI_ASSERT_IMP(a_div_done, aclk, aresetn, div_stat.done,
        state_reg == ST_DIV_WAIT, "divider finished outside its wait state")
    `CTI_ASSERT_NXT(a_clear, aclk, aresetn, s_beat && s_tuser == CMD_CLEAR,
        count_reg == '0, "clear left entries")
endmodule

// ----- test/tb_calibration_table_interpolator_core.sv -----
`timescale 1ns / 1ps
module tb_calibration_table_interpolator_core;
    import cti_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [4:0]  held;
        logic [23:0] freq;
        logic        full;
    } cal_result_t;

    // Scoreboard: holds a private copy of the calibration table and the
    // rough-model registers, predicts each result and checks the outputs.
    class cal_scoreboard;
        logic [15:0] keys [TABLE_DEPTH];
        logic [23:0] vals [TABLE_DEPTH];
        int          used;
        logic [23:0] burst;
        logic [15:0] center;
        logic [7:0]  slope;
        cal_result_t pending [$];
        int          errors;
        int          checked;

        function void reset_state();
            used = 0;
            burst = 24'd4000000;
            center = 16'd16500;
            slope = 8'd10;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            if (idx == CFG_BURST) burst = data;
            else if (idx == CFG_CENTER) center = data[15:0];
            else if (idx == CFG_SLOPE) slope = data[7:0];
        endfunction

        function logic [23:0] sat_freq(longint f);
            if (f < 0) return '0;
            if (f > longint'(FREQ_MAX)) return FREQ_MAX;
            return f[23:0];
        endfunction

        function logic [23:0] interpolate(logic [15:0] k);
            longint dv, df, dk;
            if (used == 0)
                return sat_freq(longint'(burst)
                                + longint'(slope) * (longint'(k) - longint'(center)));
            if (k <= keys[0]) return vals[0];
            if (k >= keys[used-1]) return vals[used-1];
            for (int i = 0; i + 1 < used; i++) begin
                if (k >= keys[i] && k < keys[i+1]) begin
                    dv = longint'(keys[i+1]) - longint'(keys[i]);
                    df = longint'(vals[i+1]) - longint'(vals[i]);
                    dk = longint'(k) - longint'(keys[i]);
                    return sat_freq(longint'(vals[i]) + (dk * df) / dv);
                end
            end
            return vals[used-1];
        endfunction

        function logic store_point(logic [15:0] k, logic [23:0] v);
            int pos;
            for (int j = 0; j < used; j++) begin
                if (keys[j] == k) begin
                    vals[j] = v;
                    return 1'b0;
                end
            end
            if (used >= TABLE_DEPTH) return 1'b1;
            pos = 0;
            while (pos < used && keys[pos] < k) pos++;
            for (int j = used; j > pos; j--) begin
                keys[j] = keys[j-1];
                vals[j] = vals[j-1];
            end
            keys[pos] = k;
            vals[pos] = v;
            used++;
            return 1'b0;
        endfunction

        function void note_command(logic [1:0] cmd, logic [15:0] k, logic [23:0] v);
            cal_result_t r;
            r = '0;
            if (cmd == CMD_INSERT) r.full = store_point(k, v);
            else if (cmd == CMD_CLEAR) used = 0;
            else if (cmd == CMD_LOOKUP) r.freq = interpolate(k);
            r.held = used[4:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] data);
            cal_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (data[0] !== exp_r.full) begin
                $display("%0t: status expected %0d actual %0d", $realtime, exp_r.full, data[0]);
                errors++;
            end
            if (data[24:1] !== exp_r.freq) begin
                $display("%0t: frequency expected %0d actual %0d",
                         $realtime, exp_r.freq, data[24:1]);
                errors++;
            end
            if (data[29:25] !== exp_r.held) begin
                $display("%0t: entries_held expected %0d actual %0d",
                         $realtime, exp_r.held, data[29:25]);
                errors++;
            end
            if (data[31:30] !== 2'b00) begin
                $display("%0t: pad bits expected 0 actual %b", $realtime, data[31:30]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    cal_scoreboard board;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_cycles = 0;
    int  sent_count = 0;
    logic [15:0] known_keys [$];

    always #10 aclk = ~aclk;

    calibration_table_interpolator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Receiver: check each beat, stall at random or for a long hold-off.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Drive one command beat; insert random sender gaps first. The block is
    // never ready in the cycle after a beat, so drop valid for that cycle.
    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] k,
                            input logic [23:0] v);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {v, k};
        do @(posedge aclk); while (!s_tready);
        board.note_command(cmd, k, v);
        sent_count++;
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    // Block is idle when this is called: write one register.
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(2) == 0)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(20000, 12000));
    endfunction

    // One well-formed session: clear, fill with random or repeated keys, then
    // mostly lookups, mixing in updates, overflow inserts and spare commands.
    task automatic run_session(input int n);
        int fill;
        logic [15:0] k;
        send_cmd(CMD_CLEAR, 16'($urandom), 24'($urandom));
        known_keys.delete();
        fill = $urandom_range(4) == 0 ? 18 : $urandom_range(12);
        for (int i = 0; i < fill; i++) begin
            k = pick_key();
            known_keys.push_back(k);
            send_cmd(CMD_INSERT, k, 24'($urandom));
        end
        for (int i = fill + 1; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: begin
                    k = pick_key();
                    known_keys.push_back(k);
                    send_cmd(CMD_INSERT, k, 24'($urandom));
                end
                2: send_cmd(CMD_SPARE, 16'($urandom), 24'($urandom));
                default: begin
                    k = pick_key();
                    if ($urandom_range(3) == 0 && k != 16'hFFFF) k = k + 1;
                    send_cmd(CMD_LOOKUP, k, 24'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        #20ms;
        $display("FAIL calibration_table_interpolator_core");
        $finish;
    end

    initial begin
        board = new();
        board.reset_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-table model at field extremes and at the center, then a spare command.
        send_cmd(CMD_LOOKUP, 16'd0, 24'd0);
        send_cmd(CMD_LOOKUP, 16'hFFFF, 24'hFFFFFF);
        send_cmd(CMD_LOOKUP, 16'd16500, 24'd0);
        send_cmd(CMD_SPARE, 16'hFFFF, 24'hFFFFFF);
        // Build table, exact-match update, clamps, interpolation with falling slope.
        send_cmd(CMD_INSERT, 16'd20000, 24'd100);
        send_cmd(CMD_INSERT, 16'd10000, 24'hFFFFFF);
        send_cmd(CMD_INSERT, 16'd15000, 24'd5000);
        send_cmd(CMD_INSERT, 16'd15000, 24'd7000);
        send_cmd(CMD_LOOKUP, 16'd0, 24'd0);
        send_cmd(CMD_LOOKUP, 16'hFFFF, 24'd0);
        send_cmd(CMD_LOOKUP, 16'd12345, 24'd0);
        send_cmd(CMD_LOOKUP, 16'd17777, 24'd0);
        send_cmd(CMD_LOOKUP, 16'd15000, 24'd0);
        // Fill to full, reject a new key, update a held key while full.
        for (int i = 0; i < 14; i++) send_cmd(CMD_INSERT, 16'(i * 4000 + 1), 24'(i * 999));
        send_cmd(CMD_INSERT, 16'd3, 24'd1);
        send_cmd(CMD_INSERT, 16'd1, 24'd42);
        send_cmd(CMD_LOOKUP, 16'd2000, 24'd0);
        send_cmd(CMD_CLEAR, 16'd0, 24'd0);
        drain();

        // Random phases across register settings and idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(CFG_BURST, 24'd1); write_reg(CFG_CENTER, 24'd0);
                         write_reg(CFG_SLOPE, 24'd255); end
                1: begin write_reg(CFG_BURST, 24'hFFFFFF); write_reg(CFG_CENTER, 24'hFFFF);
                         write_reg(CFG_SLOPE, 24'd0); end
                default: begin write_reg(CFG_BURST, 24'($urandom_range(16777215, 1)));
                         write_reg(CFG_CENTER, 24'($urandom_range(65535)));
                         write_reg(CFG_SLOPE, 24'($urandom_range(255))); end
            endcase
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 50 : 30) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 50 : 30) : 0;
            if (ph == 4) hold_off_cycles = 400;
            for (int s = 0; s < 6; s++) run_session(28);
            // Pause the sender until all results are back.
            while (board.pending.size() != 0) @(posedge aclk);
            send_cmd(CMD_LOOKUP, 16'($urandom), 24'd0);
            drain();
        end

        $display("Sent %0d command beats, checked %0d results over 8 register settings",
                 sent_count, board.checked);
        $display("with empty, partial, full and overflowing tables under mixed idling");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS calibration_table_interpolator_core");
        end else begin
            $display("FAIL calibration_table_interpolator_core");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/cti_pkg.sv
src/cti_div.sv
src/calibration_table_interpolator_core.sv
test/tb_calibration_table_interpolator_core.sv
